[hw/rtl/palindromic_tree_builder_macros.svh]
// assertion macros used by the palindromic tree builder rtl
`ifndef PALINDROMIC_TREE_BUILDER_MACROS_SVH
`define PALINDROMIC_TREE_BUILDER_MACROS_SVH

// condition holds at every clock edge outside reset
`define PTB_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("palindromic tree builder check failed");

// consequent holds in the cycle after the antecedent
`define PTB_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palindromic tree builder sequence check failed");

`endif

[hw/rtl/ptb_pkg.sv]
// types, constants and helpers of the palindromic tree builder
package ptb_pkg;

	localparam int MAX_LEN     = 4096;
	localparam int ALPHABET    = 26;
	localparam int NODE_DEPTH  = MAX_LEN + 2;
	localparam int TEXT_DEPTH  = MAX_LEN + 1;
	localparam int CHILD_DEPTH = NODE_DEPTH * ALPHABET;
	localparam int NW          = $clog2(NODE_DEPTH);
	localparam int TAW         = $clog2(TEXT_DEPTH);
	localparam int CAW         = $clog2(CHILD_DEPTH);
	localparam int LW          = 13;
	localparam int SW          = 5;
	localparam int MW          = NW + SW;

	typedef logic [NW-1:0]  node_t;
	typedef logic [LW-1:0]  len_t;
	typedef logic [SW-1:0]  letter_t;
	typedef logic [CAW-1:0] caddr_t;

	localparam node_t NODE_EMPTY = node_t'(0);
	localparam node_t NODE_IMAG  = node_t'(1);
	localparam node_t NODE_FIRST = node_t'(2);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_CMP,
		S_LEN,
		S_CRD,
		S_CWT,
		S_META,
		S_LNK,
		S_WR,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic chk;
		logic step;
		logic len_ld;
		logic crd;
		logic cwt;
		logic meta;
		logic wr;
	} ptb_cmd_t;

	typedef struct packed {
		logic full;
		logic node_is1;
		logic match;
		logic next_is1;
		logic entry_ok;
		logic phase;
		logic can_grow;
		logic now_is1;
	} ptb_sts_t;

	function automatic letter_t sym_mod(input letter_t s);
		return (s >= letter_t'(ALPHABET)) ? letter_t'(s - letter_t'(ALPHABET)) : s;
	endfunction

	function automatic caddr_t child_addr(input node_t n, input letter_t l);
		return caddr_t'(caddr_t'(n) * caddr_t'(ALPHABET)) + caddr_t'(l);
	endfunction

endpackage

[hw/rtl/ptb_ram.sv]
// generic single write port ram with registered read
module ptb_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/ptb_ctrl.sv]
// controller state machine of the palindromic tree builder
module ptb_ctrl import ptb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  ptb_sts_t sts,
	output ptb_cmd_t cmd
);

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.full ? S_OUT : S_CHK;
				end
			end
			S_CHK: state_nxt = sts.node_is1 ? S_CRD : S_CMP;
			S_CMP: begin
				if (sts.match) begin
					state_nxt = S_CRD;
				end else begin
					state_nxt = sts.next_is1 ? S_CHK : S_LEN;
				end
			end
			S_LEN: state_nxt = S_CHK;
			S_CRD: state_nxt = S_CWT;
			S_CWT: state_nxt = S_META;
			S_META: begin
				priority if (sts.phase) begin
					state_nxt = S_WR;
				end else if (sts.entry_ok || !sts.can_grow) begin
					state_nxt = S_OUT;
				end else if (sts.now_is1) begin
					state_nxt = S_WR;
				end else begin
					state_nxt = S_LNK;
				end
			end
			S_LNK: state_nxt = sts.next_is1 ? S_CHK : S_LEN;
			S_WR: state_nxt = S_OUT;
			S_OUT: begin
				if (!out_stall) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_CHK:  cmd.chk    = !sts.node_is1;
			S_CMP:  cmd.step   = !sts.match;
			S_LEN:  cmd.len_ld = 1'b1;
			S_CRD:  cmd.crd    = 1'b1;
			S_CWT:  cmd.cwt    = 1'b1;
			S_META: cmd.meta   = 1'b1;
			S_LNK:  cmd.step   = 1'b1;
			S_WR:   cmd.wr     = 1'b1;
			S_OUT:  out_valid  = 1'b1;
			default: cmd = '0;
		endcase
	end

endmodule

[hw/rtl/ptb_dp.sv]
// datapath of the palindromic tree builder: string, node tables and child table
`include "palindromic_tree_builder_macros.svh"
module ptb_dp import ptb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ptb_cmd_t cmd,
	output ptb_sts_t sts,
	input  letter_t  symbol,
	input  logic     first,
	output len_t     suffix_pal_length,
	output logic     new_palindrome,
	output len_t     odd_distinct_count,
	output logic     full_res
);

	len_t    tl_q, lsn_len_q, odd_q, nlen_q, nowlen_q, res_len_q;
	node_t   ncnt_q, lsn_q, node_q, now_q, e_q, link_q;
	letter_t letter_q;
	logic    phase_q, pos0_q, made_q, full_q;

	len_t    tl_eff, lsn_len_eff, pos, newlen;
	node_t   lsn_eff, nxt;
	logic    full, ok;

	logic           text_we;
	logic [TAW-1:0] text_waddr, text_raddr;
	letter_t        text_rd;
	node_t          nlen_raddr, link_rd, par_rd;
	len_t           nlen_rd;
	letter_t        let_rd;
	logic [MW-1:0]  meta_rd;
	node_t          child_rd;

	// a start flag sees the tree as if just cleared
	assign tl_eff      = first ? '0 : tl_q;
	assign lsn_eff     = first ? NODE_EMPTY : lsn_q;
	assign lsn_len_eff = first ? '0 : lsn_len_q;
	assign full        = (tl_eff == len_t'(MAX_LEN));

	assign pos    = len_t'(tl_q - nlen_q - len_t'(1));
	assign nxt    = (node_q == NODE_EMPTY) ? NODE_IMAG : link_rd;
	assign newlen = (now_q == NODE_IMAG) ? len_t'(1) : len_t'(nowlen_q + len_t'(2));
	assign par_rd = meta_rd[MW-1:SW];
	assign let_rd = meta_rd[SW-1:0];

	// a child entry counts only if it names a live node made from this parent and letter
	assign ok = (e_q >= NODE_FIRST) && (e_q < ncnt_q) && (par_rd == node_q)
		&& (let_rd == letter_q);

	assign text_we    = cmd.load && !full;
	assign text_waddr = TAW'(tl_eff + len_t'(1));
	assign text_raddr = TAW'(pos);
	assign nlen_raddr = cmd.cwt ? child_rd : nxt;

	ptb_ram #(.W(SW), .D(TEXT_DEPTH)) u_text (
		.clk   (clk),
		.we    (text_we),
		.waddr (text_waddr),
		.wdata (sym_mod(symbol)),
		.raddr (text_raddr),
		.rdata (text_rd)
	);

	ptb_ram #(.W(LW), .D(NODE_DEPTH)) u_nlen (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (ncnt_q),
		.wdata (newlen),
		.raddr (nlen_raddr),
		.rdata (nlen_rd)
	);

	ptb_ram #(.W(NW), .D(NODE_DEPTH)) u_link (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (ncnt_q),
		.wdata (link_q),
		.raddr (node_q),
		.rdata (link_rd)
	);

	ptb_ram #(.W(MW), .D(NODE_DEPTH)) u_meta (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (ncnt_q),
		.wdata ({now_q, letter_q}),
		.raddr (child_rd),
		.rdata (meta_rd)
	);

	ptb_ram #(.W(NW), .D(CHILD_DEPTH)) u_child (
		.clk   (clk),
		.we    (cmd.wr),
		.waddr (child_addr(now_q, letter_q)),
		.wdata (ncnt_q),
		.raddr (child_addr(node_q, letter_q)),
		.rdata (child_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q      <= '0;
			ncnt_q    <= NODE_FIRST;
			lsn_q     <= NODE_EMPTY;
			lsn_len_q <= '0;
			odd_q     <= '0;
			phase_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (first) begin
					ncnt_q    <= NODE_FIRST;
					odd_q     <= '0;
					lsn_q     <= NODE_EMPTY;
					lsn_len_q <= '0;
					tl_q      <= '0;
				end
				if (!full) begin
					tl_q <= len_t'(tl_eff + len_t'(1));
				end
				phase_q <= 1'b0;
			end
			if (cmd.meta) begin
				phase_q <= 1'b1;
				if (!phase_q) begin
					if (ok) begin
						lsn_q     <= e_q;
						lsn_len_q <= nlen_rd;
					end else if (!sts.can_grow) begin
						lsn_q     <= NODE_EMPTY;
						lsn_len_q <= '0;
					end
				end
			end
			if (cmd.wr) begin
				ncnt_q    <= node_t'(ncnt_q + node_t'(1));
				lsn_q     <= ncnt_q;
				lsn_len_q <= newlen;
				if (newlen[0] && (newlen >= len_t'(3))) begin
					odd_q <= len_t'(odd_q + len_t'(1));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			letter_q  <= sym_mod(symbol);
			node_q    <= lsn_eff;
			nlen_q    <= lsn_len_eff;
			res_len_q <= lsn_len_eff;
			made_q    <= 1'b0;
			full_q    <= full;
		end
		if (cmd.chk) begin
			pos0_q <= (pos == '0);
		end
		if (cmd.step) begin
			node_q <= nxt;
		end
		if (cmd.len_ld) begin
			// the empty root has no stored length
			nlen_q <= (node_q == NODE_EMPTY) ? '0 : nlen_rd;
		end
		if (cmd.crd && !phase_q) begin
			now_q    <= node_q;
			nowlen_q <= nlen_q;
		end
		if (cmd.cwt) begin
			e_q <= child_rd;
		end
		if (cmd.meta) begin
			if (!phase_q) begin
				link_q <= NODE_EMPTY;
				if (ok) begin
					res_len_q <= nlen_rd;
				end else if (!sts.can_grow) begin
					res_len_q <= '0;
				end
			end else begin
				link_q <= ok ? e_q : NODE_EMPTY;
			end
		end
		if (cmd.wr) begin
			res_len_q <= newlen;
			made_q    <= 1'b1;
		end
	end

	always_comb begin
		sts.full     = full;
		sts.node_is1 = (node_q == NODE_IMAG);
		sts.match    = !pos0_q && (text_rd == letter_q);
		sts.next_is1 = (nxt == NODE_IMAG);
		sts.entry_ok = ok;
		sts.phase    = phase_q;
		sts.can_grow = (ncnt_q < node_t'(NODE_DEPTH));
		sts.now_is1  = (now_q == NODE_IMAG);
	end

	assign suffix_pal_length  = res_len_q;
	assign new_palindrome     = made_q;
	assign odd_distinct_count = odd_q;
	assign full_res           = full_q;

	`PTB_ASSERT_ALWAYS(a_ncnt_bound, ncnt_q <= node_t'(NODE_DEPTH))
	`PTB_ASSERT_ALWAYS(a_lsn_not_imag, lsn_q != NODE_IMAG)
	`PTB_ASSERT_ALWAYS(a_text_bound, tl_q <= len_t'(MAX_LEN))
	`PTB_ASSERT_NEXT(a_wr_grows, cmd.wr, ncnt_q == node_t'($past(ncnt_q) + node_t'(1)))

endmodule

[hw/rtl/palindromic_tree_builder.sv]
// sequence: a letter refused on a full buffer goes straight to the result; otherwise the
// suffix link walk runs until the letter matches, the child table entry is read and checked,
// and a new node and its suffix link are made when no child is found and the table has room
// throughput: one letter at a time, the next letter is taken the cycle after the result leaves
// reset: counters cleared at once, no clearing pass; stale child entries fail an owner check
// top level of the palindromic tree builder
module palindromic_tree_builder import ptb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  letter_t symbol,
	input  logic    first,
	output logic    out_valid,
	input  logic    out_stall,
	output len_t    suffix_pal_length,
	output logic    new_palindrome,
	output len_t    odd_distinct_count,
	output logic    full_res
);

	ptb_cmd_t cmd;
	ptb_sts_t sts;

	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ptb_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.symbol             (symbol),
		.first              (first),
		.suffix_pal_length  (suffix_pal_length),
		.new_palindrome     (new_palindrome),
		.odd_distinct_count (odd_distinct_count),
		.full_res           (full_res)
	);

endmodule
